### hw/rtl/fit_policy_block_allocator_assert.svh
// ----------------------------------------------------------------------------
// Fit policy block allocator assertion macros
// Concurrent checks clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define FPBA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpba assertion failed");

`define FPBA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpba assertion failed");

`else

`define FPBA_ASSERT_IMP(label, ante, cons)

`define FPBA_ASSERT_NXT(label, ante, cons)

`endif

`endif

### hw/rtl/fpba_pkg.sv
// ----------------------------------------------------------------------------
// Fit policy block allocator package
// Shared widths, codes and types of the allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpba_pkg;

  localparam int NUM_BLOCKS_DEF  = 16;
  localparam int SIZE_BITS_DEF   = 16;

  localparam int FUNC_BITS       = 1;
  localparam int OUT_IDX_BITS    = 4;
  localparam int OUT_SIZE_BITS   = 16;
  localparam int MODE_BITS       = 2;
  localparam int COUNT_BITS      = 5;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 8;

  localparam logic [FUNC_BITS-1:0] FUNC_LOAD  = 1'b0;
  localparam logic [FUNC_BITS-1:0] FUNC_ALLOC = 1'b1;

  localparam logic [MODE_BITS-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_BITS-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_BITS-1:0] FIT_WORST = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FIT_MODE    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_COUNT = 2'd1;

  localparam logic [MODE_BITS-1:0]  FIT_MODE_RESET    = FIT_FIRST;
  localparam logic [COUNT_BITS-1:0] BLOCK_COUNT_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic fits;
    logic better;
  } cmp_flags_t;

endpackage

`default_nettype wire

### hw/rtl/fpba_table.sv
// ----------------------------------------------------------------------------
// Free size table
// One write port, one registered read port; unwritten entries read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpba_table #(
  parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF,
  localparam int IDX_W     = $clog2(NUM_BLOCKS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 we,
  input  wire logic [IDX_W-1:0]     waddr,
  input  wire logic [SIZE_BITS-1:0] wdata,
  input  wire logic                 rd_en,
  input  wire logic [IDX_W-1:0]     raddr,
  output logic      [SIZE_BITS-1:0] rd_data
);

  logic [SIZE_BITS-1:0]  mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] valid;
  logic [SIZE_BITS-1:0]  rd_q;
  logic                  rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= valid[raddr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

`default_nettype wire

### hw/rtl/fpba_cmp.sv
// ----------------------------------------------------------------------------
// Fit compare unit
// Checks one entry against the request and the current pick, forms remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpba_cmp #(
  parameter int SIZE_BITS = fpba_pkg::SIZE_BITS_DEF
) (
  input  wire logic [fpba_pkg::MODE_BITS-1:0] mode,
  input  wire logic [SIZE_BITS-1:0]           value,
  input  wire logic [SIZE_BITS-1:0]           req,
  input  wire logic [SIZE_BITS-1:0]           pick_val,
  output fpba_pkg::cmp_flags_t                flags,
  output logic      [SIZE_BITS-1:0]           diff
);

  always_comb begin
    flags.fits = (value >= req);
    case (mode)
      fpba_pkg::FIT_BEST:  flags.better = (value < pick_val);
      fpba_pkg::FIT_WORST: flags.better = (value > pick_val);
      default:             flags.better = 1'b0;
    endcase
  end

  assign diff = value - req;

endmodule

`default_nettype wire

### hw/rtl/fpba_seq.sv
// ----------------------------------------------------------------------------
// Allocator sequencer
// Loads entries, scans the table one entry a cycle and writes back the pick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpba_seq #(
  parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF,
  localparam int IDX_W     = $clog2(NUM_BLOCKS)
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic [fpba_pkg::FUNC_BITS-1:0]         func,
  input  wire logic [fpba_pkg::OUT_IDX_BITS-1:0]      block_index,
  input  wire logic [fpba_pkg::OUT_SIZE_BITS-1:0]     block_size,
  input  wire logic [fpba_pkg::OUT_SIZE_BITS-1:0]     request_size,
  input  wire logic [fpba_pkg::MODE_BITS-1:0]         fit_mode,
  input  wire logic [fpba_pkg::COUNT_BITS-1:0]        block_count,
  output logic                                        tbl_we,
  output logic      [IDX_W-1:0]                       tbl_waddr,
  output logic      [SIZE_BITS-1:0]                   tbl_wdata,
  output logic                                        tbl_rd_en,
  output logic      [IDX_W-1:0]                       tbl_raddr,
  input  wire logic [SIZE_BITS-1:0]                   tbl_rd_data,
  output logic                                        done,
  output logic                                        granted,
  output logic      [fpba_pkg::OUT_IDX_BITS-1:0]      chosen_block,
  output logic      [fpba_pkg::OUT_SIZE_BITS-1:0]     remaining_size
);

  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int OIW   = fpba_pkg::OUT_IDX_BITS;
  localparam int OSW   = fpba_pkg::OUT_SIZE_BITS;

  fpba_pkg::seq_state_t state, state_next;

  logic [SIZE_BITS-1:0]           req;
  logic [CNT_W-1:0]               limit;
  logic [fpba_pkg::MODE_BITS-1:0] mode;
  logic [CNT_W-1:0]               idx;
  logic                           pend;
  logic [IDX_W-1:0]               pend_idx;
  logic                           found;
  logic [IDX_W-1:0]               pick_idx;
  logic [SIZE_BITS-1:0]           pick_val;
  logic [SIZE_BITS-1:0]           pick_rem;
  logic                           done_next;

  logic                           accept;
  logic                           load_go;
  logic                           load_hit;
  logic                           take;
  fpba_pkg::cmp_flags_t           flags;
  logic [SIZE_BITS-1:0]           diff;

  fpba_cmp #(
    .SIZE_BITS (SIZE_BITS)
  ) u_cmp (
    .mode     (mode),
    .value    (tbl_rd_data),
    .req      (req),
    .pick_val (pick_val),
    .flags    (flags),
    .diff     (diff)
  );

  assign busy     = (state != fpba_pkg::ST_IDLE);
  assign accept   = start && (state == fpba_pkg::ST_IDLE);
  assign load_go  = accept && (func == fpba_pkg::FUNC_LOAD);
  assign load_hit = (32'(block_index) < NUM_BLOCKS);
  assign take     = pend && flags.fits && (!found || flags.better);

  always_comb begin
    state_next = state;
    case (state)
      fpba_pkg::ST_IDLE: begin
        if (accept && (func == fpba_pkg::FUNC_ALLOC)) begin
          state_next = fpba_pkg::ST_SCAN;
        end
      end
      fpba_pkg::ST_SCAN: begin
        if (!tbl_rd_en && !pend) begin
          state_next = fpba_pkg::ST_FINISH;
        end
      end
      fpba_pkg::ST_FINISH: state_next = fpba_pkg::ST_IDLE;
      default:             state_next = fpba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    tbl_rd_en = (state == fpba_pkg::ST_SCAN) && (idx < limit);
    tbl_raddr = idx[IDX_W-1:0];
    tbl_we    = 1'b0;
    tbl_waddr = pick_idx;
    tbl_wdata = pick_rem;
    done_next = load_go || (state == fpba_pkg::ST_FINISH);
    if (load_go && load_hit) begin
      tbl_we    = 1'b1;
      tbl_waddr = IDX_W'(block_index);
      tbl_wdata = SIZE_BITS'(block_size);
    end else if ((state == fpba_pkg::ST_FINISH) && found) begin
      tbl_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpba_pkg::ST_IDLE;
      done  <= 1'b0;
      pend  <= 1'b0;
      found <= 1'b0;
      idx   <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      pend  <= tbl_rd_en;
      if (accept) begin
        idx   <= '0;
        found <= 1'b0;
      end else begin
        if (tbl_rd_en) begin
          idx <= idx + 1'b1;
        end
        if (take) begin
          found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req  <= SIZE_BITS'(request_size);
      mode <= fit_mode;
      if (32'(block_count) > NUM_BLOCKS) begin
        limit <= CNT_W'(NUM_BLOCKS);
      end else begin
        limit <= CNT_W'(block_count);
      end
    end
    if (tbl_rd_en) begin
      pend_idx <= tbl_raddr;
    end
    if (take) begin
      pick_idx <= pend_idx;
      pick_val <= tbl_rd_data;
      pick_rem <= diff;
    end
    if (load_go) begin
      granted      <= 1'b0;
      chosen_block <= block_index;
      remaining_size <= load_hit ? OSW'(SIZE_BITS'(block_size)) : '0;
    end else if (state == fpba_pkg::ST_FINISH) begin
      granted        <= found;
      chosen_block   <= found ? OIW'(pick_idx) : '0;
      remaining_size <= found ? OSW'(pick_rem) : '0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// Fit policy block allocator
// Free size table with first, best and worst fit placement.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: raise start with func and its fields; the word is taken
//   at a clock edge where start is high and busy is low.
//   A load word writes one table entry; its result is registered and busy
//   never rises, so a new word may follow in the next cycle.
//   An allocate word scans entries 0 to min(block_count, NUM_BLOCKS)-1, one
//   entry a cycle through the single table read port and one compare unit.
//   busy is high through the scan and finish states and the result shows in
//   the cycle after, registered from the finish state.
//   Each result is on granted, chosen_block and remaining_size with done high
//   for one cycle; the receiver cannot stall it.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; write
//   only while idle. cfg_ready is always high.
//   Reset: rst is synchronous; the table reads as all zero, fit_mode returns
//   to first fit and block_count to 16. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fit_policy_block_allocator_assert.svh"

module fit_policy_block_allocator #(
  parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic [fpba_pkg::FUNC_BITS-1:0]         func,
  input  wire logic [fpba_pkg::OUT_IDX_BITS-1:0]      block_index,
  input  wire logic [fpba_pkg::OUT_SIZE_BITS-1:0]     block_size,
  input  wire logic [fpba_pkg::OUT_SIZE_BITS-1:0]     request_size,
  output logic                                        done,
  output logic                                        granted,
  output logic      [fpba_pkg::OUT_IDX_BITS-1:0]      chosen_block,
  output logic      [fpba_pkg::OUT_SIZE_BITS-1:0]     remaining_size,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [fpba_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [fpba_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);

  logic [fpba_pkg::MODE_BITS-1:0]  fit_mode;
  logic [fpba_pkg::COUNT_BITS-1:0] block_count;

  logic                 tbl_we;
  logic [IDX_W-1:0]     tbl_waddr;
  logic [SIZE_BITS-1:0] tbl_wdata;
  logic                 tbl_rd_en;
  logic [IDX_W-1:0]     tbl_raddr;
  logic [SIZE_BITS-1:0] tbl_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode    <= fpba_pkg::FIT_MODE_RESET;
      block_count <= fpba_pkg::BLOCK_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fpba_pkg::REG_FIT_MODE:    fit_mode    <= cfg_data[fpba_pkg::MODE_BITS-1:0];
        fpba_pkg::REG_BLOCK_COUNT: block_count <= cfg_data[fpba_pkg::COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  fpba_table #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .we      (tbl_we),
    .waddr   (tbl_waddr),
    .wdata   (tbl_wdata),
    .rd_en   (tbl_rd_en),
    .raddr   (tbl_raddr),
    .rd_data (tbl_rd_data)
  );

  fpba_seq #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .block_index    (block_index),
    .block_size     (block_size),
    .request_size   (request_size),
    .fit_mode       (fit_mode),
    .block_count    (block_count),
    .tbl_we         (tbl_we),
    .tbl_waddr      (tbl_waddr),
    .tbl_wdata      (tbl_wdata),
    .tbl_rd_en      (tbl_rd_en),
    .tbl_raddr      (tbl_raddr),
    .tbl_rd_data    (tbl_rd_data),
    .done           (done),
    .granted        (granted),
    .chosen_block   (chosen_block),
    .remaining_size (remaining_size)
  );

  `FPBA_ASSERT_NXT(a_accept_progress, start && !busy, busy || done)
  `FPBA_ASSERT_IMP(a_done_when_idle, done, !busy)
  `FPBA_ASSERT_IMP(a_busy_from_alloc, $rose(busy), $past(start) && ($past(func) == fpba_pkg::FUNC_ALLOC))

endmodule

`default_nettype wire

### tb/tb_fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// Fit policy block allocator testbench
// Drives load and allocate words through the command channel under all fit
// modes and several block counts. A local copy of the free size table
// predicts every result, and the monitor checks each one in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fit_policy_block_allocator;
  import fpba_pkg::*;

  localparam int TABLE_DEPTH = NUM_BLOCKS_DEF;
  localparam int PHASES = 12;
  localparam int WORDS_PER_PHASE = 133;

  localparam logic [MODE_BITS-1:0] FIT_SPARE = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

  typedef struct {
    logic [FUNC_BITS-1:0]     func;
    logic [OUT_IDX_BITS-1:0]  block_index;
    logic [OUT_SIZE_BITS-1:0] block_size;
    logic [OUT_SIZE_BITS-1:0] request_size;
    int unsigned              gap;
  } alloc_word_t;

  typedef struct packed {
    logic                     granted;
    logic [OUT_IDX_BITS-1:0]  chosen;
    logic [OUT_SIZE_BITS-1:0] remaining;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [FUNC_BITS-1:0] func = FUNC_LOAD;
  logic [OUT_IDX_BITS-1:0] block_index = '0;
  logic [OUT_SIZE_BITS-1:0] block_size = '0;
  logic [OUT_SIZE_BITS-1:0] request_size = '0;
  logic done;
  logic granted;
  logic [OUT_IDX_BITS-1:0] chosen_block;
  logic [OUT_SIZE_BITS-1:0] remaining_size;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  alloc_word_t   word_q[$];
  alloc_result_t placement_q[$];
  alloc_word_t   cur_word;
  alloc_result_t want;

  logic [OUT_SIZE_BITS-1:0] free_tbl[TABLE_DEPTH];
  logic [MODE_BITS-1:0]     fit_mode_m = FIT_MODE_RESET;
  logic [COUNT_BITS-1:0]    blk_count_m = BLOCK_COUNT_RESET;

  int idle_left = 0;
  int burst_left = 0;
  int fail_cnt = 0;
  int load_cnt = 0;
  int grant_cnt = 0;
  int deny_cnt = 0;

  fit_policy_block_allocator u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .block_index    (block_index),
    .block_size     (block_size),
    .request_size   (request_size),
    .done           (done),
    .granted        (granted),
    .chosen_block   (chosen_block),
    .remaining_size (remaining_size),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) free_tbl[i] = '0;
  end

  function automatic alloc_result_t place_word(alloc_word_t w);
    alloc_result_t r;
    int lim;
    bit found;
    int pick;
    r = '0;
    found = 1'b0;
    pick = 0;
    if (w.func == FUNC_LOAD) begin
      free_tbl[w.block_index] = w.block_size;
      r.chosen = w.block_index;
      r.remaining = w.block_size;
    end else begin
      lim = (blk_count_m > TABLE_DEPTH) ? TABLE_DEPTH : int'(blk_count_m);
      for (int j = 0; j < lim; j++) begin
        if (free_tbl[j] < w.request_size) continue;
        if (!found) begin
          found = 1'b1;
          pick = j;
          if (fit_mode_m != FIT_BEST && fit_mode_m != FIT_WORST) break;
        end else if (fit_mode_m == FIT_BEST && free_tbl[j] < free_tbl[pick]) begin
          pick = j;
        end else if (fit_mode_m == FIT_WORST && free_tbl[j] > free_tbl[pick]) begin
          pick = j;
        end
      end
      if (found) begin
        free_tbl[pick] = free_tbl[pick] - w.request_size;
        r.granted = 1'b1;
        r.chosen = pick[OUT_IDX_BITS-1:0];
        r.remaining = free_tbl[pick];
      end
    end
    return r;
  endfunction

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_left = 0;
    end else if (start && !busy) begin
      placement_q.push_back(place_word(cur_word));
      if (word_q.size() != 0 && word_q[0].gap == 0) begin
        cur_word = word_q.pop_front();
        func <= cur_word.func;
        block_index <= cur_word.block_index;
        block_size <= cur_word.block_size;
        request_size <= cur_word.request_size;
      end else begin
        start <= 1'b0;
        idle_left = (word_q.size() != 0) ? int'(word_q[0].gap) - 1 : 0;
      end
    end else if (!start && word_q.size() != 0) begin
      if (idle_left > 0) begin
        idle_left--;
      end else begin
        cur_word = word_q.pop_front();
        start <= 1'b1;
        func <= cur_word.func;
        block_index <= cur_word.block_index;
        block_size <= cur_word.block_size;
        request_size <= cur_word.request_size;
      end
    end
  end

  // config shadow
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FIT_MODE) fit_mode_m = cfg_data[MODE_BITS-1:0];
      else if (cfg_index == REG_BLOCK_COUNT) blk_count_m = cfg_data[COUNT_BITS-1:0];
    end
  end

  task automatic report_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (placement_q.size() == 0) begin
        $display("%0t ns: result with nothing expected, granted %0d block %0d size %0d",
                 $time, granted, chosen_block, remaining_size);
        fail_cnt++;
      end else begin
        want = placement_q.pop_front();
        report_field("granted", 32'(want.granted), 32'(granted));
        report_field("chosen_block", 32'(want.chosen), 32'(chosen_block));
        report_field("remaining_size", 32'(want.remaining), 32'(remaining_size));
        if (want.granted) grant_cnt++;
        else if (chosen_block == want.chosen && want.remaining != 0) load_cnt++;
        else deny_cnt++;
      end
    end
  end

  function automatic int unsigned draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  task automatic push_word(logic [FUNC_BITS-1:0] f, int unsigned idx, int unsigned bsz,
                           int unsigned req);
    alloc_word_t w;
    w.func = f;
    w.block_index = idx[OUT_IDX_BITS-1:0];
    w.block_size = bsz[OUT_SIZE_BITS-1:0];
    w.request_size = req[OUT_SIZE_BITS-1:0];
    w.gap = draw_gap();
    word_q.push_back(w);
  endtask

  task automatic push_random_word();
    int unsigned pick;
    int unsigned sz;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 0) begin
      if (pick < 70) sz = $urandom_range(0, 40);
      else if (pick < 85) sz = $urandom_range(0, 2000);
      else sz = $urandom_range(0, 65535);
      push_word(FUNC_LOAD, $urandom_range(0, 15), sz, $urandom_range(0, 65535));
    end else begin
      if (pick < 10) sz = 0;
      else if (pick < 70) sz = $urandom_range(1, 20);
      else if (pick < 90) sz = $urandom_range(0, 2000);
      else sz = $urandom_range(0, 65535);
      push_word(FUNC_ALLOC, $urandom_range(0, 15), $urandom_range(0, 65535), sz);
    end
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (word_q.size() != 0 || start || busy || placement_q.size() != 0);
  endtask

  initial begin : stimulus
    int counts[PHASES];
    logic [MODE_BITS-1:0] mode;
    logic [CFG_DATA_BITS-1:0] data;
    counts = '{16, 1, 2, 5, 0, 31, 17, 8, 16, 12, 16, 3};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // empty table, then fill and carve
    push_word(FUNC_ALLOC, 7, 65535, 0);
    push_word(FUNC_ALLOC, 0, 0, 1);
    push_word(FUNC_LOAD, 15, 65535, 0);
    push_word(FUNC_LOAD, 0, 0, 65535);
    push_word(FUNC_LOAD, 1, 16'h5555, 16'hAAAA);
    push_word(FUNC_LOAD, 2, 16'hAAAA, 16'h5555);
    push_word(FUNC_LOAD, 3, 100, 0);
    push_word(FUNC_LOAD, 4, 100, 0);
    push_word(FUNC_ALLOC, 0, 0, 65535);
    push_word(FUNC_ALLOC, 0, 0, 100);
    push_word(FUNC_ALLOC, 0, 0, 0);
    push_word(FUNC_ALLOC, 15, 65535, 65535);
    push_word(FUNC_ALLOC, 0, 0, 16'h5555);
    push_word(FUNC_LOAD, 14, 50, 0);
    push_word(FUNC_ALLOC, 0, 0, 100);
    push_word(FUNC_ALLOC, 0, 0, 101);
    push_word(FUNC_LOAD, 15, 1, 0);
    push_word(FUNC_ALLOC, 0, 0, 1);
    wait_idle();
    for (int p = 0; p < PHASES; p++) begin
      mode = MODE_BITS'(p % 4);
      data = CFG_DATA_BITS'($urandom_range(0, 255));
      data[MODE_BITS-1:0] = mode;
      write_reg(REG_FIT_MODE, data);
      data = CFG_DATA_BITS'($urandom_range(0, 255));
      data[COUNT_BITS-1:0] = COUNT_BITS'(counts[p]);
      if (p == 5) data = 8'hFF;
      write_reg(REG_BLOCK_COUNT, data);
      if (p % 3 == 2) begin
        write_reg((p % 2) ? REG_SPARE_HI : REG_SPARE_LO,
                  CFG_DATA_BITS'($urandom_range(0, 255)));
      end
      @(negedge clk);
      if (mode == FIT_SPARE) push_word(FUNC_ALLOC, 0, 0, 0);
      for (int k = 0; k < WORDS_PER_PHASE; k++) push_random_word();
      wait_idle();
    end
    repeat (40) @(posedge clk);
    $display("Ran %0d fit phases over all modes and block counts 0 to 31.", PHASES);
    $display("Results: %0d grants, %0d nonzero loads, %0d denials or zero loads.",
             grant_cnt, load_cnt, deny_cnt);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d words and %0d results pending",
             word_q.size(), placement_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### fit_policy_block_allocator.f
+incdir+hw/rtl
hw/rtl/fpba_pkg.sv
hw/rtl/fpba_table.sv
hw/rtl/fpba_cmp.sv
hw/rtl/fpba_seq.sv
hw/rtl/fit_policy_block_allocator.sv
tb/tb_fit_policy_block_allocator.sv
